// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every cycle outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/drt_pkg.sv =====
// ----------------------------------------------------------------------------
// drt_pkg
// Shared types and codes of the damage region tracker.
// ----------------------------------------------------------------------------
package drt_pkg;
  localparam logic [3:0] REQ_WIN_START = 4'd0;
  localparam logic [3:0] REQ_WIN_STOP  = 4'd1;
  localparam logic [3:0] REQ_MON_START = 4'd2;
  localparam logic [3:0] REQ_MON_STOP  = 4'd3;
  localparam logic [3:0] REQ_WIN_MOVE  = 4'd4;
  localparam logic [3:0] REQ_MON_MOVE  = 4'd5;
  localparam logic [3:0] REQ_MON_ADD   = 4'd6;
  localparam logic [3:0] REQ_DAMAGE    = 4'd7;
  localparam logic [3:0] REQ_CURSOR    = 4'd8;
  localparam logic [3:0] REQ_CLEAR     = 4'd9;
  localparam logic [15:0] COUNT_TOP    = 16'hFFFF;

  typedef struct packed {
    logic [15:0] h;
    logic [15:0] w;
    logic [15:0] y;
    logic [15:0] x;
  } rect_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture request
    logic scan_win; // examine window entry at scan index
    logic scan_mon; // examine monitor entry at scan index
    logic commit;   // apply result and build output word
  } dp_cmd_t;

  // strict overlap of two rectangles, 18-bit signed edge arithmetic
  function automatic logic overlap(rect_t a, rect_t b);
    logic signed [17:0] ax, ay, bx, by, ar, ab, br, bb;
    ax = 18'(signed'(a.x));
    ay = 18'(signed'(a.y));
    bx = 18'(signed'(b.x));
    by = 18'(signed'(b.y));
    ar = ax + signed'({2'b00, a.w});
    ab = ay + signed'({2'b00, a.h});
    br = bx + signed'({2'b00, b.w});
    bb = by + signed'({2'b00, b.h});
    return (ax < br) && (ar > bx) && (ay < bb) && (ab > by);
  endfunction
endpackage

// ===== rtl/damage_region_tracker_top.sv =====
// ----------------------------------------------------------------------------
// damage_region_tracker_top
// Damage region tracker.
// Input channel: in_valid_i / in_stall_o with one request word (req_type_i,
// target_id_i, all_monitors_i, pos/size, cursor_visible_i). A word is taken
// when in_valid_i is high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i with ok_o and damaged_o; one
// result word per request, taken when out_valid_o is high and out_stall_i low.
// Configuration: cfg_we_i writes cfg_idx_i (0 tracking_enabled,
// 1 cursor_tracking) with cfg_data_i; the user must write only while idle, the block does not enforce it.
// Each request runs a sequential scan of both tables, one entry per cycle,
// then a commit state. One request is in flight at a time, so a new word is
// taken only after the result word of the last one has been taken.
// Reset: tables empty, dirty flag set, tracking on, cursor tracking off.
// A stalled result holds on the output and no new word is taken meanwhile.
// ----------------------------------------------------------------------------
module damage_region_tracker_top import drt_pkg::*; #(
  parameter int unsigned MAX_WINDOWS  = 16,
  parameter int unsigned MAX_MONITORS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  req_type_i,
  input  logic [31:0] target_id_i,
  input  logic        all_monitors_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic [15:0] width_i,
  input  logic [15:0] height_i,
  input  logic        cursor_visible_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        ok_o,
  output logic        damaged_o
);
  localparam int unsigned ScanMax = (MAX_WINDOWS > MAX_MONITORS) ? MAX_WINDOWS : MAX_MONITORS;
  localparam int unsigned CW = $clog2(ScanMax + 1);

  logic track_en_q, cur_track_q;
  logic [CW-1:0] idx;
  dp_cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_en_q  <= 1'b1;
      cur_track_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == 1'b0) track_en_q <= cfg_data_i;
      else cur_track_q <= cfg_data_i;
    end
  end

  drt_ctrl #(.ScanMax(ScanMax)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .out_stall_i,
    .n_win_i(CW'(MAX_WINDOWS)), .n_mon_i(CW'(MAX_MONITORS)),
    .in_stall_o, .out_valid_o, .idx_o(idx), .cmd_o(cmd)
  );

  drt_dp #(.MaxWindows(MAX_WINDOWS), .MaxMonitors(MAX_MONITORS), .CW(CW)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .idx_i(idx),
    .tracking_enabled_i(track_en_q), .cursor_tracking_i(cur_track_q),
    .req_type_i, .target_id_i, .all_monitors_i,
    .pos_x_i(pos_x_i), .pos_y_i(pos_y_i), .width_i, .height_i, .cursor_visible_i,
    .ok_o, .damaged_o
  );
endmodule

// ===== rtl/drt_ctrl.sv =====
// ----------------------------------------------------------------------------
// drt_ctrl
// Sequencer: load, scan windows, scan monitors, commit, hold output.
// ----------------------------------------------------------------------------
module drt_ctrl import drt_pkg::*; #(
  parameter int unsigned ScanMax = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic out_stall_i,
  input  logic [$clog2(ScanMax+1)-1:0] n_win_i,
  input  logic [$clog2(ScanMax+1)-1:0] n_mon_i,
  output logic in_stall_o,
  output logic out_valid_o,
  output logic [$clog2(ScanMax+1)-1:0] idx_o,
  output dp_cmd_t cmd_o
);
  localparam int unsigned CW = $clog2(ScanMax + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_WIN  = 5'b00010,
    ST_MON  = 5'b00100,
    ST_CMT  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] idx_q, idx_d;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign idx_o       = idx_q;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_WIN;
          idx_d = '0;
        end
      end
      ST_WIN: begin
        cmd_o.scan_win = 1'b1;
        if (idx_q == n_win_i - CW'(1)) begin
          idx_d = '0;
          state_d = ST_MON;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      ST_MON: begin
        cmd_o.scan_mon = 1'b1;
        if (idx_q == n_mon_i - CW'(1)) begin
          idx_d = '0;
          state_d = ST_CMT;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      ST_CMT: begin
        cmd_o.commit = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_onehot, clk_i, rst_ni, 1'b1, $onehot(state_q))
  `ASSERT_NEXT(a_load_scan, clk_i, rst_ni, cmd_o.load, state_q == ST_WIN && idx_q == '0)
  `ASSERT_NEXT(a_cmt_out, clk_i, rst_ni, cmd_o.commit, out_valid_o)
endmodule

// ===== rtl/drt_dp.sv =====
// ----------------------------------------------------------------------------
// drt_dp
// Tables, request register, scan accumulators and result register.
// ----------------------------------------------------------------------------
module drt_dp import drt_pkg::*; #(
  parameter int unsigned MaxWindows  = 16,
  parameter int unsigned MaxMonitors = 8,
  parameter int unsigned CW = 5
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  dp_cmd_t cmd_i,
  input  logic [CW-1:0] idx_i,
  input  logic tracking_enabled_i,
  input  logic cursor_tracking_i,
  input  logic [3:0] req_type_i,
  input  logic [31:0] target_id_i,
  input  logic all_monitors_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [15:0] width_i,
  input  logic [15:0] height_i,
  input  logic cursor_visible_i,
  output logic ok_o,
  output logic damaged_o
);
  localparam int unsigned WW = (MaxWindows > 1) ? $clog2(MaxWindows) : 1;
  localparam int unsigned MW = (MaxMonitors > 1) ? $clog2(MaxMonitors) : 1;

  logic [31:0] win_id_q  [MaxWindows];
  rect_t       win_rect_q[MaxWindows];
  logic [15:0] win_ref_q [MaxWindows];
  logic [31:0] mon_id_q  [MaxMonitors];
  rect_t       mon_rect_q[MaxMonitors];
  logic [15:0] mon_ref_q [MaxMonitors];
  logic [MaxMonitors-1:0] mon_pres_q;
  logic [15:0] whole_q;
  logic        dirty_q;
  logic [31:0] cursor_q;

  logic [3:0]  req_q;
  logic [31:0] id_q;
  logic        all_q, vis_q;
  rect_t       rect_q;

  // scan results
  logic          wfound_q, wfree_q, mfound_q, mfree_q, whit_q, mhit_q;
  logic [WW-1:0] widx_q, wfidx_q;
  logic [MW-1:0] midx_q, mfidx_q;
  logic ok_q, dmg_q;

  logic [WW-1:0] wi;
  logic [MW-1:0] mi;
  assign wi = idx_i[WW-1:0];
  assign mi = idx_i[MW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_type_i;
      id_q   <= target_id_i;
      all_q  <= all_monitors_i;
      vis_q  <= cursor_visible_i;
      rect_q <= '{h: height_i, w: width_i, y: pos_y_i, x: pos_x_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wfound_q <= 1'b0; wfree_q <= 1'b0; mfound_q <= 1'b0; mfree_q <= 1'b0;
      whit_q <= 1'b0; mhit_q <= 1'b0;
      widx_q <= '0; wfidx_q <= '0; midx_q <= '0; mfidx_q <= '0;
    end else if (cmd_i.load) begin
      wfound_q <= 1'b0; wfree_q <= 1'b0; mfound_q <= 1'b0; mfree_q <= 1'b0;
      whit_q <= 1'b0; mhit_q <= 1'b0;
    end else if (cmd_i.scan_win) begin
      if (win_ref_q[wi] != '0) begin
        if (!wfound_q && win_id_q[wi] == id_q) begin
          wfound_q <= 1'b1;
          widx_q   <= wi;
        end
        if (overlap(win_rect_q[wi], rect_q)) whit_q <= 1'b1;
      end else if (!wfree_q) begin
        wfree_q <= 1'b1;
        wfidx_q <= wi;
      end
    end else if (cmd_i.scan_mon) begin
      if (mon_pres_q[mi]) begin
        if (!mfound_q && mon_id_q[mi] == id_q) begin
          mfound_q <= 1'b1;
          midx_q   <= mi;
        end
        if (mon_ref_q[mi] != '0 && overlap(mon_rect_q[mi], rect_q)) mhit_q <= 1'b1;
      end else if (!mfree_q) begin
        mfree_q <= 1'b1;
        mfidx_q <= mi;
      end
    end
  end

  logic id_nz, rect_nz;
  assign id_nz   = (id_q != '0);
  assign rect_nz = (rect_q.w != '0) && (rect_q.h != '0);

  // ids and rects: payload, written only at commit
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && tracking_enabled_i) begin
      case (req_q)
        REQ_WIN_START: if (id_nz && !wfound_q && wfree_q) begin
          win_id_q[wfidx_q]   <= id_q;
          win_rect_q[wfidx_q] <= rect_q;
        end
        REQ_WIN_MOVE: if (id_nz && wfound_q) win_rect_q[widx_q] <= rect_q;
        REQ_MON_MOVE: if (id_nz && rect_nz && mfound_q) mon_rect_q[midx_q] <= rect_q;
        REQ_MON_ADD: if (id_nz) begin
          if (mfound_q) mon_rect_q[midx_q] <= rect_q;
          else if (mfree_q) begin
            mon_id_q[mfidx_q]   <= id_q;
            mon_rect_q[mfidx_q] <= rect_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MaxWindows; k++) win_ref_q[k] <= '0;
      for (int k = 0; k < MaxMonitors; k++) mon_ref_q[k] <= '0;
      mon_pres_q <= '0;
      whole_q    <= '0;
      dirty_q    <= 1'b1;
      cursor_q   <= '0;
      ok_q       <= 1'b0;
      dmg_q      <= 1'b1;
    end else if (cmd_i.commit) begin
      ok_q  <= 1'b0;
      dmg_q <= 1'b1;
      if (tracking_enabled_i) begin
        dmg_q <= dirty_q;
        case (req_q)
          REQ_WIN_START: if (id_nz) begin
            if (wfound_q) begin
              if (win_ref_q[widx_q] != COUNT_TOP) win_ref_q[widx_q] <= win_ref_q[widx_q] + 16'd1;
              ok_q <= 1'b1;
            end else if (wfree_q) begin
              win_ref_q[wfidx_q] <= 16'd1;
              ok_q <= 1'b1;
            end
          end
          REQ_WIN_STOP: if (id_nz && wfound_q) begin
            win_ref_q[widx_q] <= win_ref_q[widx_q] - 16'd1;
            ok_q <= 1'b1;
          end
          REQ_MON_START: begin
            if (all_q) begin
              if (whole_q != COUNT_TOP) whole_q <= whole_q + 16'd1;
              ok_q <= 1'b1;
            end else if (id_nz && mfound_q) begin
              if (mon_ref_q[midx_q] != COUNT_TOP) mon_ref_q[midx_q] <= mon_ref_q[midx_q] + 16'd1;
              ok_q <= 1'b1;
            end
          end
          REQ_MON_STOP: begin
            if (all_q) begin
              if (whole_q != '0) whole_q <= whole_q - 16'd1;
              ok_q <= 1'b1;
            end else if (id_nz && mfound_q && mon_ref_q[midx_q] != '0) begin
              mon_ref_q[midx_q] <= mon_ref_q[midx_q] - 16'd1;
              ok_q <= 1'b1;
            end
          end
          REQ_WIN_MOVE: ok_q <= id_nz && wfound_q;
          REQ_MON_MOVE: ok_q <= id_nz && rect_nz && mfound_q;
          REQ_MON_ADD: if (id_nz) begin
            if (mfound_q) ok_q <= 1'b1;
            else if (mfree_q) begin
              mon_ref_q[mfidx_q]  <= '0;
              mon_pres_q[mfidx_q] <= 1'b1;
              ok_q <= 1'b1;
            end
          end
          REQ_DAMAGE: begin
            ok_q <= 1'b1;
            if (dirty_q || whole_q != '0 || (id_nz && wfound_q) || mhit_q) begin
              dirty_q <= 1'b1;
              dmg_q   <= 1'b1;
            end
          end
          REQ_CURSOR: begin
            ok_q <= 1'b1;
            if (cursor_tracking_i && vis_q && !dirty_q &&
                {rect_q.y, rect_q.x} != cursor_q) begin
              cursor_q <= {rect_q.y, rect_q.x};
              if (whole_q != '0 || whit_q || mhit_q) begin
                dirty_q <= 1'b1;
                dmg_q   <= 1'b1;
              end
            end
          end
          REQ_CLEAR: begin
            ok_q    <= 1'b1;
            dirty_q <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  assign ok_o      = ok_q;
  assign damaged_o = dmg_q;

  `include "assert_macros.svh"
  `ASSERT_NEXT(a_clear, clk_i, rst_ni,
    cmd_i.commit && tracking_enabled_i && req_q == REQ_CLEAR, !dirty_q && ok_q)
  `ASSERT_NEXT(a_off, clk_i, rst_ni, cmd_i.commit && !tracking_enabled_i, !ok_q && dmg_q)
  `ASSERT_IMPL(a_cmd_excl, clk_i, rst_ni, 1'b1, $onehot0(cmd_i))
endmodule

// ===== tb/sv/tb_damage_region_tracker_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_damage_region_tracker_top
// Request-level test of the damage region tracker.
// Each accepted request word runs through a local copy of the window and
// monitor tables. The expected ok/damaged pair is queued and compared with
// every result word. The run covers directed cases, full tables, cursor ticks,
// the disabled mode, a long output hold-off, and random traffic.
// ----------------------------------------------------------------------------
module tb_damage_region_tracker_top;
  import drt_pkg::*;

  localparam int NWIN = 16;
  localparam int NMON = 8;
  localparam int SETTLE = NWIN + NMON + 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic REG_TRACKING = 1'b0;
  localparam logic REG_CURSOR   = 1'b1;
  localparam logic [3:0] REQ_SPARE_TOP = 4'd15;

  typedef struct {
    logic [3:0]         kind;
    logic [31:0]        id;
    logic               whole;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        w;
    logic [15:0]        h;
    logic               vis;
  } request_t;

  typedef struct {
    logic ok;
    logic dmg;
  } verdict_t;

  logic clk_i, rst_ni, cfg_we_i, cfg_idx_i, cfg_data_i;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i, ok_o, damaged_o;
  logic [3:0] req_type_i;
  logic [31:0] target_id_i;
  logic all_monitors_i, cursor_visible_i;
  logic signed [15:0] pos_x_i, pos_y_i;
  logic [15:0] width_i, height_i;

  damage_region_tracker_top u_top (.*);

  // local copy of the block state
  logic [31:0] win_id [NWIN];
  rect_t       win_rect [NWIN];
  logic [15:0] win_ref [NWIN];
  logic [31:0] mon_id [NMON];
  logic        mon_on [NMON];
  rect_t       mon_rect [NMON];
  logic [15:0] mon_ref [NMON];
  logic [15:0] screen_cnt;
  logic        dirty;
  logic [31:0] cursor_last;
  logic        trk_en, cur_en;

  verdict_t verdicts_due [$];
  int  errors;
  int  cycles;
  logic calm, hold_rx;
  int  stall_left;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic rects_meet(rect_t a, rect_t b);
    int ax, ay, bx, by;
    ax = $signed(a.x);
    ay = $signed(a.y);
    bx = $signed(b.x);
    by = $signed(b.y);
    return ax < bx + int'(b.w) && ax + int'(a.w) > bx &&
           ay < by + int'(b.h) && ay + int'(a.h) > by;
  endfunction

  function automatic logic [15:0] bump(logic [15:0] c);
    return (c == COUNT_TOP) ? c : c + 16'd1;
  endfunction

  function automatic int find_win(logic [31:0] id);
    for (int i = 0; i < NWIN; i++)
      if (win_ref[i] != 0 && win_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int find_mon(logic [31:0] id);
    for (int i = 0; i < NMON; i++)
      if (mon_on[i] && mon_id[i] == id) return i;
    return -1;
  endfunction

  function automatic logic hits_mon(rect_t a);
    for (int i = 0; i < NMON; i++)
      if (mon_on[i] && mon_ref[i] != 0 && rects_meet(mon_rect[i], a)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic hits_win(rect_t a);
    for (int i = 0; i < NWIN; i++)
      if (win_ref[i] != 0 && rects_meet(win_rect[i], a)) return 1'b1;
    return 1'b0;
  endfunction

  // advance the table copy by one request and return the expected result
  function automatic verdict_t track_request(request_t r);
    verdict_t v;
    rect_t a;
    int i;
    logic done;
    a = '{h: r.h, w: r.w, y: r.y, x: r.x};
    v.ok = 1'b0;
    if (!trk_en) begin
      v.dmg = 1'b1;
      return v;
    end
    case (r.kind)
      REQ_WIN_START: if (r.id != 0) begin
        i = find_win(r.id);
        if (i >= 0) begin
          win_ref[i] = bump(win_ref[i]);
          v.ok = 1'b1;
        end else begin
          done = 1'b0;
          for (int k = 0; k < NWIN; k++)
            if (!done && win_ref[k] == 0) begin
              win_id[k] = r.id;
              win_rect[k] = a;
              win_ref[k] = 16'd1;
              done = 1'b1;
            end
          v.ok = done;
        end
      end
      REQ_WIN_STOP: if (r.id != 0) begin
        i = find_win(r.id);
        if (i >= 0) begin
          win_ref[i]--;
          v.ok = 1'b1;
        end
      end
      REQ_MON_START: if (r.whole) begin
        screen_cnt = bump(screen_cnt);
        v.ok = 1'b1;
      end else if (r.id != 0) begin
        i = find_mon(r.id);
        if (i >= 0) begin
          mon_ref[i] = bump(mon_ref[i]);
          v.ok = 1'b1;
        end
      end
      REQ_MON_STOP: if (r.whole) begin
        if (screen_cnt != 0) screen_cnt--;
        v.ok = 1'b1;
      end else if (r.id != 0) begin
        i = find_mon(r.id);
        if (i >= 0 && mon_ref[i] != 0) begin
          mon_ref[i]--;
          v.ok = 1'b1;
        end
      end
      REQ_WIN_MOVE: if (r.id != 0) begin
        i = find_win(r.id);
        if (i >= 0) begin
          win_rect[i] = a;
          v.ok = 1'b1;
        end
      end
      REQ_MON_MOVE: if (r.id != 0 && r.w != 0 && r.h != 0) begin
        i = find_mon(r.id);
        if (i >= 0) begin
          mon_rect[i] = a;
          v.ok = 1'b1;
        end
      end
      REQ_MON_ADD: if (r.id != 0) begin
        i = find_mon(r.id);
        if (i >= 0) begin
          mon_rect[i] = a;
          v.ok = 1'b1;
        end else begin
          done = 1'b0;
          for (int k = 0; k < NMON; k++)
            if (!done && !mon_on[k]) begin
              mon_id[k] = r.id;
              mon_rect[k] = a;
              mon_ref[k] = '0;
              mon_on[k] = 1'b1;
              done = 1'b1;
            end
          v.ok = done;
        end
      end
      REQ_DAMAGE: begin
        v.ok = 1'b1;
        if (screen_cnt != 0) dirty = 1'b1;
        if (!dirty && r.id != 0 && find_win(r.id) >= 0) dirty = 1'b1;
        if (!dirty && hits_mon(a)) dirty = 1'b1;
      end
      REQ_CURSOR: begin
        v.ok = 1'b1;
        if (cur_en && r.vis && !dirty && {r.y, r.x} != cursor_last) begin
          cursor_last = {r.y, r.x};
          if (screen_cnt != 0 || hits_win(a) || hits_mon(a)) dirty = 1'b1;
        end
      end
      REQ_CLEAR: begin
        v.ok = 1'b1;
        v.dmg = dirty;
        dirty = 1'b0;
        return v;
      end
      default: ;
    endcase
    v.dmg = dirty;
    return v;
  endfunction

  task automatic report_mismatch(string what, logic got, logic want);
    $display("[%0t] mismatch on %s: got %b, want %b", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    verdict_t v;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch("unexpected word", out_valid_o, 1'b0);
      end else begin
        v = verdicts_due.pop_front();
        if (ok_o !== v.ok) report_mismatch("ok", ok_o, v.ok);
        if (damaged_o !== v.dmg) report_mismatch("damaged", damaged_o, v.dmg);
      end
    end
  end

  // receiver stall: random bursts, or a long hold when asked
  initial begin
    out_stall_i = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_rx) out_stall_i = 1'b1;
      else if (stall_left > 0) begin
        stall_left--;
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = 1'b0;
        if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 10);
      end
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_word(request_t r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    req_type_i = r.kind;
    target_id_i = r.id;
    all_monitors_i = r.whole;
    pos_x_i = r.x;
    pos_y_i = r.y;
    width_i = r.w;
    height_i = r.h;
    cursor_visible_i = r.vis;
    do @(posedge clk_i); while (in_stall_o);
    verdicts_due.push_back(track_request(r));
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send(logic [3:0] kind, logic [31:0] id, logic whole = 1'b0,
                      int x = 0, int y = 0, int w = 10, int h = 10,
                      logic vis = 1'b1);
    request_t r;
    r = '{kind: kind, id: id, whole: whole, x: 16'(x), y: 16'(y),
          w: 16'(w), h: 16'(h), vis: vis};
    send_word(r);
  endtask

  task automatic wait_drain();
    while (verdicts_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic val);
    wait_drain();
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    if (idx == REG_TRACKING) trk_en = val;
    else cur_en = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic request_t random_word();
    request_t r;
    int p;
    p = $urandom_range(0, 99);
    if (p < 14) r.kind = REQ_WIN_START;
    else if (p < 24) r.kind = REQ_WIN_STOP;
    else if (p < 32) r.kind = REQ_MON_START;
    else if (p < 40) r.kind = REQ_MON_STOP;
    else if (p < 48) r.kind = REQ_WIN_MOVE;
    else if (p < 54) r.kind = REQ_MON_MOVE;
    else if (p < 58) r.kind = REQ_MON_ADD;
    else if (p < 74) r.kind = REQ_DAMAGE;
    else if (p < 86) r.kind = REQ_CURSOR;
    else if (p < 97) r.kind = REQ_CLEAR;
    else r.kind = 4'($urandom_range(int'(REQ_CLEAR) + 1, int'(REQ_SPARE_TOP)));
    p = $urandom_range(0, 99);
    r.id = (p < 85) ? 32'($urandom_range(1, 12)) : (p < 90) ? 32'd0 : $urandom();
    r.whole = ($urandom_range(0, 9) < 3);
    r.x = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 300) - 100) : 16'($urandom());
    r.y = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 300) - 100) : 16'($urandom());
    r.w = ($urandom_range(0, 19) < 17) ? 16'($urandom_range(0, 120)) : 16'($urandom());
    r.h = ($urandom_range(0, 19) < 17) ? 16'($urandom_range(0, 120)) : 16'($urandom());
    r.vis = 1'($urandom());
    return r;
  endfunction

  task automatic test_directed();
    send(REQ_WIN_START, 32'd0);
    send(REQ_WIN_START, 32'hFFFF_FFFF, 1'b0, -32768, 32767, 65535, 0);
    send(REQ_WIN_START, 32'hFFFF_FFFF, 1'b0, 5, 5, 5, 5);       // repeated start
    send(REQ_CLEAR, 32'd0);
    send(REQ_DAMAGE, 32'hFFFF_FFFF, 1'b0, 1000, 1000, 1, 1);    // tracked window
    send(REQ_WIN_STOP, 32'h1234_5678);                          // unknown window
    send(REQ_MON_START, 32'h8000_0001);                         // monitor missing
    send(REQ_MON_ADD, 32'h8000_0001, 1'b0, 0, 0, 100, 100);
    send(REQ_MON_ADD, 32'h8000_0001, 1'b0, 0, 0, 200, 200);     // repeated add
    send(REQ_MON_MOVE, 32'h8000_0001, 1'b0, 0, 0, 0, 50);       // empty move
    send(REQ_MON_MOVE, 32'h8000_0001, 1'b0, 0, 0, 100, 100);
    send(REQ_MON_STOP, 32'h8000_0001);                          // not tracked
    send(REQ_MON_START, 32'h8000_0001);
    send(REQ_CLEAR, 32'd0);
    send(REQ_DAMAGE, 32'd0, 1'b0, 100, 0, 10, 10);              // edges touch
    send(REQ_DAMAGE, 32'd0, 1'b0, 99, 99, 10, 10);
    send(REQ_CLEAR, 32'd0);
    send(REQ_MON_START, 32'd0, 1'b1);
    send(REQ_DAMAGE, 32'd0, 1'b0, -32768, -32768, 0, 0);
    send(REQ_MON_STOP, 32'd0, 1'b1);
    send(REQ_MON_STOP, 32'd0, 1'b1);                            // floor at zero
    send(REQ_WIN_MOVE, 32'hFFFF_FFFF, 1'b0, 32767, -1, 65535, 65535);
    send(REQ_WIN_MOVE, 32'd0);
    send(REQ_CURSOR, 32'd0, 1'b0, 3, 3, 1, 1, 1'b1);            // cursor off
    send(REQ_SPARE_TOP, 32'hFFFF_FFFF, 1'b1, -1, -1, 65535, 65535, 1'b1);
  endtask

  task automatic test_full_tables();
    for (int i = 1; i <= NWIN + 1; i++) send(REQ_WIN_START, 32'(100 + i));
    for (int i = 1; i <= NMON + 1; i++)
      send(REQ_MON_ADD, 32'(i), 1'b0, (i - 1) * 40, 0, 40, 40);
    for (int i = 1; i <= NWIN + 1; i++) send(REQ_WIN_STOP, 32'(100 + i));
    send(REQ_WIN_STOP, 32'hFFFF_FFFF);
  endtask

  task automatic test_cursor();
    write_reg(REG_CURSOR, 1'b1);
    send(REQ_MON_START, 32'd2);
    send(REQ_CLEAR, 32'd0);
    send(REQ_CURSOR, 32'd0, 1'b0, 500, 500, 4, 4, 1'b1);        // misses
    send(REQ_CURSOR, 32'd0, 1'b0, 500, 500, 4, 4, 1'b1);        // same spot
    send(REQ_CURSOR, 32'd0, 1'b0, 45, 5, 4, 4, 1'b0);           // hidden
    send(REQ_CURSOR, 32'd0, 1'b0, 45, 5, 4, 4, 1'b1);
    send(REQ_CLEAR, 32'd0);
  endtask

  task automatic test_disabled();
    write_reg(REG_TRACKING, 1'b0);
    repeat (12) send_word(random_word());
    write_reg(REG_TRACKING, 1'b1);
  endtask

  task automatic test_backlog();
    fork
      begin
        hold_rx = 1'b1;
        repeat (300) @(negedge clk_i);
        hold_rx = 1'b0;
      end
      repeat (20) send_word(random_word());
    join
    wait_drain();
  endtask

  task automatic test_random();
    for (int chunk = 0; chunk < 4; chunk++) begin
      write_reg(REG_CURSOR, chunk[0]);
      if (chunk == 3) calm = 1'b1;
      repeat (150) send_word(random_word());
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    calm = 1'b0;
    hold_rx = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = 1'b0;
    cfg_data_i = 1'b0;
    in_valid_i = 1'b0;
    req_type_i = '0;
    target_id_i = '0;
    all_monitors_i = 1'b0;
    pos_x_i = '0;
    pos_y_i = '0;
    width_i = '0;
    height_i = '0;
    cursor_visible_i = 1'b0;
    for (int i = 0; i < NWIN; i++) win_ref[i] = '0;
    for (int i = 0; i < NMON; i++) begin
      mon_on[i] = 1'b0;
      mon_ref[i] = '0;
    end
    screen_cnt = '0;
    dirty = 1'b1;
    cursor_last = '0;
    trk_en = 1'b1;
    cur_en = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (SETTLE) @(negedge clk_i);

    test_directed();
    test_full_tables();
    test_cursor();
    test_disabled();
    test_backlog();
    test_random();
    wait_drain();

    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
